@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

@@ sv/pwi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwi_pkg
// Shared widths, codes and pipeline control types for the wall interaction.
// ----------------------------------------------------------------------------
package pwi_pkg;

	// Field widths
	localparam int VW = 32;             // velocity, Q16.16
	localparam int NW = 16;             // normal, Q2.14
	localparam int CW = 15;             // restitution and friction, unsigned Q1.14

	// Internal arithmetic widths
	localparam int RW   = VW + 1;       // relative velocity
	localparam int PW   = RW + NW;      // r_i * n_i
	localparam int DW   = PW + 2;       // dot product sum
	localparam int QSH  = 14;           // Q2.14 shift
	localparam int UW   = DW - QSH;     // normal speed Un
	localparam int QW   = UW + NW;      // Un * n_i
	localparam int RQW  = QW - QSH;     // rounded Un * n_i
	localparam int UTW  = RQW + 1;      // tangential part
	localparam int EW   = CW + 2;       // 1 + e, signed
	localparam int KKW  = EW + UW;      // (1 + e) * Un
	localparam int KW   = KKW - QSH;    // k
	localparam int MW   = KW + NW;      // k * n_i and mu * ut_i
	localparam int RMW  = MW - QSH;     // rounded products
	localparam int SW   = RMW + 3;      // final sum before saturation

	localparam int RND_HALF = 8192;
	localparam int Q_ONE    = 16384;

	localparam int NSTG = 7;            // pipeline depth

	// Register map
	localparam int APB_AW = 4;
	localparam logic [1:0] REG_WALL_MODE   = 2'd0;
	localparam logic [1:0] REG_RESTITUTION = 2'd1;
	localparam logic [1:0] REG_FRICTION    = 2'd2;

	localparam logic [1:0]    MODE_RESET = 2'd2;
	localparam logic [CW-1:0] REST_RESET = CW'(Q_ONE);
	localparam logic [CW-1:0] FRIC_RESET = '0;

	typedef enum logic [1:0] {
		MODE_ESCAPE  = 2'd0,
		MODE_STICK   = 2'd1,
		MODE_REBOUND = 2'd2
	} mode_t;

	// What the last stage puts on the velocity outputs
	typedef enum logic [1:0] {
		SEL_PASS    = 2'd0,
		SEL_ZERO    = 2'd1,
		SEL_REBOUND = 2'd2
	} sel_t;

	typedef struct packed {
		logic [NSTG:1] adv;     // stage k loads this cycle
		logic          un_pos;  // Un > 0 for the item entering stage 6
		sel_t          sel;     // output select for the item entering stage 7
	} ctl_t;

	typedef struct packed {
		logic          handled;
		logic          keep;
		logic          act;
		sel_t          sel;
		logic [31:0]   esc;
		logic [31:0]   stk;
	} meta_t;

endpackage

@@ sv/pwi_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwi_lane
// One velocity axis of the rebound pipeline: relative velocity, normal
// product, tangential part, restitution and friction terms, saturation.
// ----------------------------------------------------------------------------
module pwi_lane (
	input  logic                             clk,
	input  pwi_pkg::ctl_t                    ctl,
	input  logic signed [pwi_pkg::VW-1:0]    vel,
	input  logic signed [pwi_pkg::NW-1:0]    normal,
	input  logic signed [pwi_pkg::VW-1:0]    patch_vel,
	input  logic signed [pwi_pkg::UW-1:0]    un,
	input  logic signed [pwi_pkg::KW-1:0]    k,
	input  logic        [pwi_pkg::CW-1:0]    mu,
	output logic signed [pwi_pkg::PW-1:0]    p,
	output logic signed [pwi_pkg::VW-1:0]    result
);

	logic signed [pwi_pkg::VW-1:0]  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [pwi_pkg::NW-1:0]  n_s1, n_s2, n_s3, n_s4, n_s5;
	logic signed [pwi_pkg::RW-1:0]  r_s1, r_s2, r_s3, r_s4;
	logic signed [pwi_pkg::PW-1:0]  p_s2;
	logic signed [pwi_pkg::QW-1:0]  q_s4;
	logic signed [pwi_pkg::UTW-1:0] ut_s5;
	logic signed [pwi_pkg::MW-1:0]  a_s6, f_s6;
	logic signed [pwi_pkg::VW-1:0]  nv_s7;

	logic signed [pwi_pkg::QW-1:0]  q_half;
	logic signed [pwi_pkg::RQW-1:0] rq;
	logic signed [pwi_pkg::NW-1:0]  mu_ext;
	logic signed [pwi_pkg::MW-1:0]  a_half, f_half;
	logic signed [pwi_pkg::RMW-1:0] ra, rf;
	logic signed [pwi_pkg::SW-1:0]  sum;
	logic signed [pwi_pkg::VW-1:0]  sat;
	logic signed [pwi_pkg::VW-1:0]  nv_next;

	// Round half up: add one half, then floor by the Q2.14 shift
	assign q_half = q_s4 + pwi_pkg::QW'(pwi_pkg::RND_HALF);
	assign rq     = q_half[pwi_pkg::QW-1:pwi_pkg::QSH];
	assign mu_ext = signed'({1'b0, mu});

	assign a_half = a_s6 + pwi_pkg::MW'(pwi_pkg::RND_HALF);
	assign f_half = f_s6 + pwi_pkg::MW'(pwi_pkg::RND_HALF);
	assign ra     = a_half[pwi_pkg::MW-1:pwi_pkg::QSH];
	assign rf     = f_half[pwi_pkg::MW-1:pwi_pkg::QSH];

	// r + patch_vel is the incoming velocity, so only the two corrections remain
	assign sum = pwi_pkg::SW'(v_s6) - pwi_pkg::SW'(ra) - pwi_pkg::SW'(rf);

	always_comb begin
		if (!sum[pwi_pkg::SW-1] && (|sum[pwi_pkg::SW-2:pwi_pkg::VW-1])) begin
			sat = {1'b0, {(pwi_pkg::VW-1){1'b1}}};
		end else if (sum[pwi_pkg::SW-1] && !(&sum[pwi_pkg::SW-2:pwi_pkg::VW-1])) begin
			sat = {1'b1, {(pwi_pkg::VW-1){1'b0}}};
		end else begin
			sat = sum[pwi_pkg::VW-1:0];
		end
	end

	always_comb begin
		unique case (ctl.sel)
			pwi_pkg::SEL_PASS:    nv_next = v_s6;
			pwi_pkg::SEL_ZERO:    nv_next = '0;
			pwi_pkg::SEL_REBOUND: nv_next = sat;
			default:              nv_next = sat;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			v_s1 <= vel;
			n_s1 <= normal;
			r_s1 <= pwi_pkg::RW'(vel) - pwi_pkg::RW'(patch_vel);
		end
		if (ctl.adv[2]) begin
			v_s2 <= v_s1;
			n_s2 <= n_s1;
			r_s2 <= r_s1;
			p_s2 <= r_s1 * n_s1;
		end
		if (ctl.adv[3]) begin
			v_s3 <= v_s2;
			n_s3 <= n_s2;
			r_s3 <= r_s2;
		end
		if (ctl.adv[4]) begin
			v_s4 <= v_s3;
			n_s4 <= n_s3;
			r_s4 <= r_s3;
			q_s4 <= un * n_s3;
		end
		if (ctl.adv[5]) begin
			v_s5  <= v_s4;
			n_s5  <= n_s4;
			ut_s5 <= pwi_pkg::UTW'(r_s4) - pwi_pkg::UTW'(rq);
		end
		if (ctl.adv[6]) begin
			v_s6 <= v_s5;
			f_s6 <= mu_ext * ut_s5;
			if (ctl.un_pos) begin
				a_s6 <= k * n_s5;
			end else begin
				a_s6 <= '0;
			end
		end
		if (ctl.adv[7]) begin
			nv_s7 <= nv_next;
		end
	end

	assign p      = p_s2;
	assign result = nv_s7;

endmodule

@@ sv/particle_wall_interaction_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_wall_interaction_top
// Particle-wall hit: pass-through, escape, stick or rebound with restitution
// and friction; saturating escape and stick counters.
// ----------------------------------------------------------------------------
// Use: present one hit per beat on the item channel (item_valid/item_ready);
// one result beat per item leaves on the result channel in the same order.
// Configure wall_mode, restitution and friction over the APB port while no
// item is in flight; reads return the register values, pready is tied high.
// Pipeline: an item passes through 7 register stages set by the chain of
// multiplications (r.n, Un*n, k*n and mu*ut, each followed by a rounding).
// Throughput: one item per cycle unless a low result_ready stalls the
// pipeline.
// Reset: clears the pipeline valid bits and both counters, and sets rebound
// mode, restitution 1.0 and friction 0.
// Stall: when result_ready is low the last stage holds its beat; earlier
// stages keep moving into empty slots, so item_ready stays high until the
// whole pipeline is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module particle_wall_interaction_top (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pwi_pkg::APB_AW-1:0]           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,

	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic                                 is_wall,
	input  logic                                 keep_in,
	input  logic                                 active_in,
	input  logic signed [pwi_pkg::VW-1:0]        vel_x,
	input  logic signed [pwi_pkg::VW-1:0]        vel_y,
	input  logic signed [pwi_pkg::VW-1:0]        vel_z,
	input  logic signed [pwi_pkg::NW-1:0]        normal_x,
	input  logic signed [pwi_pkg::NW-1:0]        normal_y,
	input  logic signed [pwi_pkg::NW-1:0]        normal_z,
	input  logic signed [pwi_pkg::VW-1:0]        patch_vel_x,
	input  logic signed [pwi_pkg::VW-1:0]        patch_vel_y,
	input  logic signed [pwi_pkg::VW-1:0]        patch_vel_z,

	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic                                 handled,
	output logic                                 keep_particle,
	output logic                                 active_out,
	output logic signed [pwi_pkg::VW-1:0]        new_vel_x,
	output logic signed [pwi_pkg::VW-1:0]        new_vel_y,
	output logic signed [pwi_pkg::VW-1:0]        new_vel_z,
	output logic [31:0]                          escape_total,
	output logic [31:0]                          stick_total
);

	localparam int NSTG = pwi_pkg::NSTG;

	// Configuration
	logic [1:0]              mode_q;
	logic [pwi_pkg::CW-1:0]  rest_q;
	logic [pwi_pkg::CW-1:0]  fric_q;
	logic                    cfg_wr;
	logic [1:0]              reg_idx;

	// Counters
	logic [31:0] esc_q, stk_q;
	logic [31:0] esc_nxt, stk_nxt;
	logic        fire_in;

	// Pipeline control
	logic [NSTG:1]   valid_s;
	logic [NSTG+1:1] rdy;
	logic [NSTG:1]   adv;
	pwi_pkg::meta_t  meta_in;
	pwi_pkg::meta_t  meta_s [1:NSTG];
	pwi_pkg::ctl_t   ctl;

	// Shared rebound terms
	logic signed [pwi_pkg::PW-1:0]  p_x, p_y, p_z;
	logic signed [pwi_pkg::DW-1:0]  dot_sum;
	logic signed [pwi_pkg::UW-1:0]  un_s3;
	logic signed [pwi_pkg::EW-1:0]  e_ext;
	logic signed [pwi_pkg::KKW-1:0] kk_s4;
	logic signed [pwi_pkg::KKW-1:0] kk_half;
	logic signed [pwi_pkg::KW-1:0]  k_s5;
	logic                           pos_s4, pos_s5;
	logic                           is_escape, is_stick;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign reg_idx = paddr[pwi_pkg::APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pwi_pkg::MODE_RESET;
			rest_q <= pwi_pkg::REST_RESET;
			fric_q <= pwi_pkg::FRIC_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				pwi_pkg::REG_WALL_MODE:   mode_q <= pwdata[1:0];
				pwi_pkg::REG_RESTITUTION: rest_q <= pwdata[pwi_pkg::CW-1:0];
				pwi_pkg::REG_FRICTION:    fric_q <= pwdata[pwi_pkg::CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pwi_pkg::REG_WALL_MODE:   prdata = {30'b0, mode_q};
			pwi_pkg::REG_RESTITUTION: prdata = {{(32 - pwi_pkg::CW){1'b0}}, rest_q};
			pwi_pkg::REG_FRICTION:    prdata = {{(32 - pwi_pkg::CW){1'b0}}, fric_q};
			default:                  prdata = '0;
		endcase
	end

	// --------------------------------------------------------- entry decode
	always_comb begin
		unique case (mode_q)
			pwi_pkg::MODE_ESCAPE: begin
				is_escape = 1'b1;
				is_stick  = 1'b0;
			end
			pwi_pkg::MODE_STICK: begin
				is_escape = 1'b0;
				is_stick  = 1'b1;
			end
			default: begin
				is_escape = 1'b0;
				is_stick  = 1'b0;
			end
		endcase
	end

	assign fire_in = item_valid && item_ready;

	// Hold a counter once it is full
	assign esc_nxt = (fire_in && is_wall && is_escape && (esc_q != '1)) ? esc_q + 32'd1 : esc_q;
	assign stk_nxt = (fire_in && is_wall && is_stick && (stk_q != '1)) ? stk_q + 32'd1 : stk_q;

	always_comb begin
		meta_in.handled = is_wall;
		meta_in.esc     = esc_nxt;
		meta_in.stk     = stk_nxt;
		if (!is_wall) begin
			meta_in.keep = keep_in;
			meta_in.act  = active_in;
			meta_in.sel  = pwi_pkg::SEL_PASS;
		end else if (is_escape || is_stick) begin
			meta_in.keep = is_stick;
			meta_in.act  = 1'b0;
			meta_in.sel  = pwi_pkg::SEL_ZERO;
		end else begin
			meta_in.keep = 1'b1;
			meta_in.act  = 1'b1;
			meta_in.sel  = pwi_pkg::SEL_REBOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= '0;
			stk_q <= '0;
		end else begin
			esc_q <= esc_nxt;
			stk_q <= stk_nxt;
		end
	end

	// ------------------------------------------------------ pipeline control
	// A stage takes a new beat when it is empty or its beat moves on
	always_comb begin
		rdy[NSTG+1] = result_ready;
		for (int i = NSTG; i >= 1; i--) begin
			rdy[i] = !valid_s[i] || rdy[i+1];
		end
		adv[1] = rdy[1] && item_valid;
		for (int i = 2; i <= NSTG; i++) begin
			adv[i] = rdy[i] && valid_s[i-1];
		end
	end

	assign item_ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (rdy[1]) begin
				valid_s[1] <= item_valid;
			end
			for (int i = 2; i <= NSTG; i++) begin
				if (rdy[i]) begin
					valid_s[i] <= valid_s[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			meta_s[1] <= meta_in;
		end
		for (int i = 2; i <= NSTG; i++) begin
			if (adv[i]) begin
				meta_s[i] <= meta_s[i-1];
			end
		end
	end

	// ---------------------------------------------------- shared rebound terms
	assign dot_sum = pwi_pkg::DW'(p_x) + pwi_pkg::DW'(p_y) + pwi_pkg::DW'(p_z)
		+ pwi_pkg::DW'(pwi_pkg::RND_HALF);
	assign e_ext   = signed'({2'b00, rest_q}) + pwi_pkg::EW'(pwi_pkg::Q_ONE);
	assign kk_half = kk_s4 + pwi_pkg::KKW'(pwi_pkg::RND_HALF);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			un_s3 <= dot_sum[pwi_pkg::DW-1:pwi_pkg::QSH];
		end
		if (adv[4]) begin
			kk_s4  <= e_ext * un_s3;
			pos_s4 <= !un_s3[pwi_pkg::UW-1] && (|un_s3);
		end
		if (adv[5]) begin
			k_s5   <= kk_half[pwi_pkg::KKW-1:pwi_pkg::QSH];
			pos_s5 <= pos_s4;
		end
	end

	assign ctl.adv    = adv;
	assign ctl.un_pos = pos_s5;
	assign ctl.sel    = meta_s[NSTG-1].sel;

	pwi_lane u_lane_x (
		.clk       (clk),
		.ctl       (ctl),
		.vel       (vel_x),
		.normal    (normal_x),
		.patch_vel (patch_vel_x),
		.un        (un_s3),
		.k         (k_s5),
		.mu        (fric_q),
		.p         (p_x),
		.result    (new_vel_x)
	);

	pwi_lane u_lane_y (
		.clk       (clk),
		.ctl       (ctl),
		.vel       (vel_y),
		.normal    (normal_y),
		.patch_vel (patch_vel_y),
		.un        (un_s3),
		.k         (k_s5),
		.mu        (fric_q),
		.p         (p_y),
		.result    (new_vel_y)
	);

	pwi_lane u_lane_z (
		.clk       (clk),
		.ctl       (ctl),
		.vel       (vel_z),
		.normal    (normal_z),
		.patch_vel (patch_vel_z),
		.un        (un_s3),
		.k         (k_s5),
		.mu        (fric_q),
		.p         (p_z),
		.result    (new_vel_z)
	);

	// ----------------------------------------------------------------- outputs
	assign result_valid  = valid_s[NSTG];
	assign handled       = meta_s[NSTG].handled;
	assign keep_particle = meta_s[NSTG].keep;
	assign active_out    = meta_s[NSTG].act;
	assign escape_total  = meta_s[NSTG].esc;
	assign stick_total   = meta_s[NSTG].stk;

	// -------------------------------------------------------------- assertions
	`ASSERT_CLK(a_esc_monotonic, clk, arst_n, esc_q >= $past(esc_q), "escape counter went down")
	`ASSERT_CLK(a_stk_monotonic, clk, arst_n, stk_q >= $past(stk_q), "stick counter went down")
	`ASSERT_CLK(a_stopped_zero, clk, arst_n, (result_valid && handled && !active_out) |-> (new_vel_x == '0 && new_vel_y == '0 && new_vel_z == '0), "stopped particle has a velocity")
	`ASSERT_NEVER(a_entry_blocked, clk, arst_n, !valid_s[1] && !item_ready, "empty entry stage refused a beat")

endmodule

@@ verif/wall_hit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_hit_checker
// Watches the APB port and both beat channels of the wall interaction block.
// Keeps its own copy of the registers and the escape and stick counters,
// predicts the outcome of every accepted hit and compares each result beat,
// field by field, with the oldest outstanding prediction. Register reads are
// checked against the shadow copy.
// ----------------------------------------------------------------------------
module wall_hit_checker
	import pwi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [31:0]              pwdata,
	input  logic [31:0]              prdata,
	input  logic                     pready,

	input  logic                     item_valid,
	input  logic                     item_ready,
	input  logic                     is_wall,
	input  logic                     keep_in,
	input  logic                     active_in,
	input  logic signed [VW-1:0]     vel_x,
	input  logic signed [VW-1:0]     vel_y,
	input  logic signed [VW-1:0]     vel_z,
	input  logic signed [NW-1:0]     normal_x,
	input  logic signed [NW-1:0]     normal_y,
	input  logic signed [NW-1:0]     normal_z,
	input  logic signed [VW-1:0]     patch_vel_x,
	input  logic signed [VW-1:0]     patch_vel_y,
	input  logic signed [VW-1:0]     patch_vel_z,

	input  logic                     result_valid,
	input  logic                     result_ready,
	input  logic                     handled,
	input  logic                     keep_particle,
	input  logic                     active_out,
	input  logic signed [VW-1:0]     new_vel_x,
	input  logic signed [VW-1:0]     new_vel_y,
	input  logic signed [VW-1:0]     new_vel_z,
	input  logic [31:0]              escape_total,
	input  logic [31:0]              stick_total,

	output int                       mismatches,
	output int                       in_flight
);

	localparam longint VEL_MAX = 64'sd2147483647;
	localparam longint VEL_MIN = -64'sd2147483648;

	typedef struct packed {
		logic                handled;
		logic                keep;
		logic                act;
		logic [2:0][VW-1:0]  vel;
		logic [31:0]         esc;
		logic [31:0]         stk;
	} outcome_t;

	// Shadow registers and counters
	logic [1:0]     mode_q  = MODE_RESET;
	logic [CW-1:0]  rest_q  = REST_RESET;
	logic [CW-1:0]  fric_q  = FRIC_RESET;
	logic [31:0]    esc_cnt = '0;
	logic [31:0]    stk_cnt = '0;

	outcome_t       pending_outcomes [$];
	int             fail_count   = 0;
	int             queued_count = 0;
	int             beat_no      = 0;

	assign mismatches = fail_count;
	assign in_flight  = queued_count;

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s: got %08h, expected %08h", $time, what, got, want);
		fail_count++;
	endtask

	// Round half up of x / 2^14; arithmetic shift floors
	function automatic longint round_q14(longint x);
		return (x + longint'(RND_HALF)) >>> QSH;
	endfunction

	function automatic logic [VW-1:0] clamp_q16(longint x);
		if (x > VEL_MAX)
			return VW'(VEL_MAX);
		if (x < VEL_MIN)
			return VW'(VEL_MIN);
		return x[VW-1:0];
	endfunction

	function automatic outcome_t predict_wall_hit(logic wall, logic keep, logic act,
			logic [2:0][VW-1:0] v, logic [2:0][NW-1:0] n, logic [2:0][VW-1:0] pv);
		outcome_t o;
		longint   rel [3];
		longint   nrm [3];
		longint   pat [3];
		longint   tang [3];
		longint   dot;
		longint   un;
		longint   k;
		o = '0;
		o.keep = keep;
		o.act = act;
		o.vel = v;
		if (wall) begin
			o.handled = 1'b1;
			case (mode_q)
				MODE_ESCAPE: begin
					o.keep = 1'b0;
					o.act = 1'b0;
					o.vel = '0;
				end
				MODE_STICK: begin
					o.keep = 1'b1;
					o.act = 1'b0;
					o.vel = '0;
				end
				default: begin
					// rebound in the patch frame; the spare mode lands here too
					o.keep = 1'b1;
					o.act = 1'b1;
					dot = 0;
					for (int i = 0; i < 3; i++) begin
						nrm[i] = longint'($signed(n[i]));
						pat[i] = longint'($signed(pv[i]));
						rel[i] = longint'($signed(v[i])) - pat[i];
						dot += rel[i] * nrm[i];
					end
					un = round_q14(dot);
					for (int i = 0; i < 3; i++)
						tang[i] = rel[i] - round_q14(un * nrm[i]);
					if (un > 0) begin
						k = round_q14((longint'(Q_ONE) + longint'(rest_q)) * un);
						for (int i = 0; i < 3; i++)
							rel[i] -= round_q14(k * nrm[i]);
					end
					for (int i = 0; i < 3; i++) begin
						rel[i] -= round_q14(longint'(fric_q) * tang[i]);
						o.vel[i] = clamp_q16(rel[i] + pat[i]);
					end
				end
			endcase
		end
		return o;
	endfunction

	always @(posedge clk) begin : watch
		outcome_t            want;
		outcome_t            next_hit;
		logic [2:0][VW-1:0]  got_vel;
		logic [31:0]         reg_val;
		if (arst_n) begin
			// register port
			if (psel && penable && pready) begin
				case (paddr[APB_AW-1:2])
					REG_WALL_MODE:   reg_val = 32'(mode_q);
					REG_RESTITUTION: reg_val = 32'(rest_q);
					REG_FRICTION:    reg_val = 32'(fric_q);
					default:         reg_val = '0;
				endcase
				if (pwrite) begin
					case (paddr[APB_AW-1:2])
						REG_WALL_MODE:   mode_q = pwdata[1:0];
						REG_RESTITUTION: rest_q = pwdata[CW-1:0];
						REG_FRICTION:    fric_q = pwdata[CW-1:0];
						default: ;
					endcase
				end else if (prdata !== reg_val) begin
					flag_mismatch($sformatf("read of register %0d", paddr[APB_AW-1:2]),
						prdata, reg_val);
				end
			end

			// result beats
			if (result_valid && result_ready) begin
				if (pending_outcomes.size() == 0) begin
					flag_mismatch($sformatf("beat %0d with nothing outstanding", beat_no),
						{29'b0, handled, keep_particle, active_out}, '0);
				end else begin
					want = pending_outcomes.pop_front();
					got_vel = {new_vel_z, new_vel_y, new_vel_x};
					if (handled !== want.handled)
						flag_mismatch($sformatf("beat %0d handled", beat_no),
							32'(handled), 32'(want.handled));
					if (keep_particle !== want.keep)
						flag_mismatch($sformatf("beat %0d keep_particle", beat_no),
							32'(keep_particle), 32'(want.keep));
					if (active_out !== want.act)
						flag_mismatch($sformatf("beat %0d active_out", beat_no),
							32'(active_out), 32'(want.act));
					for (int i = 0; i < 3; i++)
						if (got_vel[i] !== want.vel[i])
							flag_mismatch($sformatf("beat %0d new_vel[%0d]", beat_no, i),
								got_vel[i], want.vel[i]);
					if (escape_total !== want.esc)
						flag_mismatch($sformatf("beat %0d escape_total", beat_no),
							escape_total, want.esc);
					if (stick_total !== want.stk)
						flag_mismatch($sformatf("beat %0d stick_total", beat_no),
							stick_total, want.stk);
				end
				beat_no++;
			end

			// hit beats
			if (item_valid && item_ready) begin
				next_hit = predict_wall_hit(is_wall, keep_in, active_in,
					{vel_z, vel_y, vel_x}, {normal_z, normal_y, normal_x},
					{patch_vel_z, patch_vel_y, patch_vel_x});
				if (is_wall && mode_q == MODE_ESCAPE && esc_cnt != '1)
					esc_cnt++;
				if (is_wall && mode_q == MODE_STICK && stk_cnt != '1)
					stk_cnt++;
				next_hit.esc = esc_cnt;
				next_hit.stk = stk_cnt;
				pending_outcomes.push_back(next_hit);
			end
			queued_count = pending_outcomes.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives particle hits and register settings into the wall interaction block:
// a directed set of edge cases, then random phases across all wall modes and
// extreme restitution and friction values, with random idling on both
// channels, a receiver hold-off and a full drain. The checker does the rest.
// ----------------------------------------------------------------------------
module testbench;
	import pwi_pkg::*;

	localparam logic [1:0] MODE_SPARE     = 2'd3;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         HOLD_CYCLES    = 80;

	typedef struct packed {
		logic                is_wall;
		logic                keep;
		logic                act;
		logic [2:0][VW-1:0]  vel;
		logic [2:0][NW-1:0]  nrm;
		logic [2:0][VW-1:0]  pvel;
	} hit_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [31:0]         pwdata, prdata;
	logic                pready;
	logic                item_valid, item_ready;
	logic                is_wall, keep_in, active_in;
	logic signed [VW-1:0] vel_x, vel_y, vel_z;
	logic signed [NW-1:0] normal_x, normal_y, normal_z;
	logic signed [VW-1:0] patch_vel_x, patch_vel_y, patch_vel_z;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic                handled, keep_particle, active_out;
	logic signed [VW-1:0] new_vel_x, new_vel_y, new_vel_z;
	logic [31:0]         escape_total, stick_total;

	int                  mismatches, in_flight;
	logic                calm = 1'b0;
	int                  hold_asked = 0;
	int                  hold_served = 0;
	int                  hold_left = 0;
	int                  quiet_cycles = 0;

	particle_wall_interaction_top dut (.*);
	wall_hit_checker checker_i (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else begin
			result_ready <= calm || ($urandom_range(99) >= 33);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [VW-1:0] rand_speed();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			return $urandom;
		if (pick < 85)
			return $signed($urandom) >>> $urandom_range(31, 8);
		case ($urandom_range(3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [NW-1:0] unit_sign(logic [NW-1:0] mag);
		return $urandom_range(1) ? mag : NW'(-$signed(mag));
	endfunction

	function automatic logic [2:0][NW-1:0] rand_normal();
		logic [2:0][NW-1:0] n;
		int pick;
		int a;
		n = '0;
		pick = $urandom_range(99);
		a = $urandom_range(2);
		if (pick < 40) begin
			n[a] = unit_sign(NW'(Q_ONE));
		end else if (pick < 60) begin
			n[a] = unit_sign(NW'(11585));
			n[(a + 1) % 3] = unit_sign(NW'(11585));
		end else if (pick < 85) begin
			for (int i = 0; i < 3; i++)
				n[i] = NW'($urandom);
		end else begin
			for (int i = 0; i < 3; i++)
				n[i] = $signed(NW'($urandom)) >>> $urandom_range(15, 1);
		end
		return n;
	endfunction

	function automatic hit_t rand_hit(int wall_pct);
		hit_t h;
		h.is_wall = ($urandom_range(99) < wall_pct);
		h.keep = 1'($urandom);
		h.act = 1'($urandom);
		h.nrm = rand_normal();
		for (int i = 0; i < 3; i++) begin
			h.vel[i] = rand_speed();
			h.pvel[i] = ($urandom_range(99) < 30) ? '0 : rand_speed();
		end
		// now and then the particle rides along with the patch
		if ($urandom_range(19) == 0)
			h.pvel = h.vel;
		return h;
	endfunction

	function automatic hit_t mk(logic w, logic k, logic a,
			logic [VW-1:0] vx, logic [VW-1:0] vy, logic [VW-1:0] vz,
			logic [NW-1:0] nx, logic [NW-1:0] ny, logic [NW-1:0] nz,
			logic [VW-1:0] px, logic [VW-1:0] py, logic [VW-1:0] pz);
		hit_t h;
		h.is_wall = w;
		h.keep = k;
		h.act = a;
		h.vel = {vz, vy, vx};
		h.nrm = {nz, ny, nx};
		h.pvel = {pz, py, px};
		return h;
	endfunction

	task automatic offer_hit(hit_t h);
		if (!calm)
			while ($urandom_range(99) < 33) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		item_valid <= 1'b1;
		is_wall <= h.is_wall;
		keep_in <= h.keep;
		active_in <= h.act;
		vel_x <= h.vel[0];
		vel_y <= h.vel[1];
		vel_z <= h.vel[2];
		normal_x <= h.nrm[0];
		normal_y <= h.nrm[1];
		normal_z <= h.nrm[2];
		patch_vel_x <= h.pvel[0];
		patch_vel_y <= h.pvel[1];
		patch_vel_z <= h.pvel[2];
		do @(posedge clk); while (!item_ready);
	endtask

	// Stop offering and wait until every outstanding beat is out
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (NSTG + 3) @(posedge clk);
	endtask

	// Setup and access phases, then idle before the next transfer
	task automatic apb_access(logic wr, logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_back();
		apb_access(1'b0, REG_WALL_MODE, '0);
		apb_access(1'b0, REG_RESTITUTION, '0);
		apb_access(1'b0, REG_FRICTION, '0);
	endtask

	task automatic set_config(logic [1:0] mode, int rest, int fric);
		settle();
		apb_access(1'b1, REG_WALL_MODE, 32'(mode));
		apb_access(1'b1, REG_RESTITUTION, 32'(rest));
		apb_access(1'b1, REG_FRICTION, 32'(fric));
		read_back();
	endtask

	task automatic random_run(int count, logic quiet, logic squeeze, logic breather);
		calm <= quiet;
		if (squeeze)
			hold_asked <= hold_asked + 1;
		for (int i = 0; i < count; i++) begin
			if (breather && i == count / 2)
				settle();
			offer_hit(rand_hit(85));
		end
		calm <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		is_wall = 1'b0;
		keep_in = 1'b0;
		active_in = 1'b0;
		vel_x = '0;
		vel_y = '0;
		vel_z = '0;
		normal_x = '0;
		normal_y = '0;
		normal_z = '0;
		patch_vel_x = '0;
		patch_vel_y = '0;
		patch_vel_z = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_back();

		// pass-through at the ends of the velocity range
		offer_hit(mk(1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			16'h7FFF, 16'h8000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
		offer_hit(mk(1'b0, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
			16'h8000, 16'h7FFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
		// head-on along the normal, moving away, and grazing
		offer_hit(mk(1'b1, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0003_0000,
			16'h0, 16'h0, 16'h4000, 32'h0, 32'h0, 32'h0));
		offer_hit(mk(1'b1, 1'b0, 1'b0, 32'h0001_0000, 32'hFFFE_0000, 32'hFFFD_0000,
			16'h0, 16'h0, 16'h4000, 32'h0, 32'h0, 32'h0));
		offer_hit(mk(1'b1, 1'b1, 1'b1, 32'h0005_0000, 32'h0002_0000, 32'h0,
			16'h0, 16'h0, 16'h4000, 32'h0, 32'h0, 32'h0));
		// oversize normals with the largest relative speed: saturation
		offer_hit(mk(1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		offer_hit(mk(1'b1, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		// normal off unit length, then a zero normal
		offer_hit(mk(1'b1, 1'b0, 1'b1, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F,
			16'h8000, 16'h7FFF, 16'h2D41, 32'h0010_0000, 32'hFFF0_0000, 32'h5555_5555));
		offer_hit(mk(1'b1, 1'b1, 1'b0, 32'hDEAD_BEEF, 32'h0123_4567, 32'h89AB_CDEF,
			16'h0, 16'h0, 16'h0, 32'h1, 32'h2, 32'h3));
		// particle moving with the patch
		offer_hit(mk(1'b1, 1'b1, 1'b1, 32'h0020_0000, 32'hFFE0_0000, 32'h0008_0000,
			16'h2D41, 16'h0, 16'hD2BF, 32'h0020_0000, 32'hFFE0_0000, 32'h0008_0000));

		// largest restitution, friction past 1.0 flips the tangential part
		set_config(MODE_REBOUND, 32767, 32767);
		offer_hit(mk(1'b1, 1'b1, 1'b1, 32'h0004_0000, 32'h0003_0000, 32'h0002_0000,
			16'h0, 16'h0, 16'h4000, 32'h0, 32'h0, 32'h0));
		offer_hit(mk(1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
			16'h2D41, 16'h2D41, 16'h0, 32'hC000_0000, 32'h0, 32'h3FFF_FFFF));

		set_config(MODE_ESCAPE, 0, 0);
		offer_hit(rand_hit(100));
		offer_hit(rand_hit(100));
		offer_hit(rand_hit(0));
		set_config(MODE_STICK, 16384, 16384);
		offer_hit(rand_hit(100));
		offer_hit(rand_hit(100));
		offer_hit(rand_hit(0));
		set_config(MODE_SPARE, 16384, 8192);
		offer_hit(rand_hit(100));
		offer_hit(rand_hit(100));

		// random phases
		set_config(MODE_REBOUND, 16384, 0);
		random_run(170, 1'b1, 1'b0, 1'b0);
		set_config(MODE_REBOUND, $urandom_range(32767), $urandom_range(16384));
		random_run(170, 1'b0, 1'b1, 1'b0);
		set_config(MODE_ESCAPE, $urandom_range(32767), $urandom_range(16384));
		random_run(110, 1'b0, 1'b0, 1'b0);
		set_config(MODE_STICK, $urandom_range(32767), $urandom_range(16384));
		random_run(110, 1'b0, 1'b0, 1'b0);
		set_config(MODE_SPARE, 0, 16384);
		random_run(170, 1'b0, 1'b0, 1'b1);
		set_config(MODE_REBOUND, 32767, 16384);
		random_run(170, 1'b0, 1'b0, 1'b0);
		set_config(MODE_REBOUND, 0, 0);
		random_run(170, 1'b0, 1'b0, 1'b0);
		set_config(MODE_REBOUND, $urandom_range(32767), 32767);
		random_run(150, 1'b0, 1'b0, 1'b0);
		set_config(MODE_REBOUND, $urandom_range(32767), $urandom_range(16384));
		random_run(310, 1'b0, 1'b0, 1'b0);
		settle();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
